[design/uvt_pkg.sv]
// shared types and constants for the unique value table with statistics
`default_nettype none
package uvt_pkg;

   localparam int TableDepthDefault = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_SEARCH = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_DIVIDE,
      S_RESPOND
   } state_type;

endpackage
`default_nettype wire

[design/unique_value_table_with_stats_core.sv]
// unique value table with min, max and mean: top level
//
// One command at a time: start is taken while busy is low, and exactly one
// response comes back later on a one-cycle rsp_valid strobe that cannot be
// stalled, so the receiver must take it when it appears. An add or a search
// scans the stored entries through the table memory, one read per cycle with
// the read data registered before the compare, and stops at the first match.
// Then an update step, then, when the table is not empty, a restoring
// divider for the mean that retires one quotient bit per cycle over the
// running sum width (33 + log2 of the depth, 39 bits at depth 64), and a
// response state. A clear or an unused opcode skips the scan.
`default_nettype none
module unique_value_table_with_stats_core #(
   parameter int TABLE_DEPTH = uvt_pkg::TableDepthDefault,
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [1:0]          req_opcode,
   input  wire  signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [IW-1:0]       rsp_position,
   output logic [CW-1:0]       rsp_entry_count,
   output logic                rsp_is_empty,
   output logic signed [31:0]  rsp_smallest,
   output logic signed [31:0]  rsp_largest,
   output logic signed [31:0]  rsp_average
);

   localparam int SW = 33 + $clog2(TABLE_DEPTH);
   localparam int DW = $clog2(SW + 1);

   // table memory
   logic [31:0] mem [TABLE_DEPTH];
   logic [31:0] rd_data_ff;
   logic        wr_en;
   logic [IW-1:0] wr_addr;

   uvt_pkg::state_type  state_ff, state_in;
   uvt_pkg::opcode_type op_ff, op_in;
   logic signed [31:0]  val_ff, val_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                pend_ff, pend_in;
   logic [IW-1:0]       pend_idx_ff, pend_idx_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       where_ff, where_in;
   uvt_pkg::status_type status_ff, status_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       count_ff, count_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [31:0]  min_ff, min_in;
   logic signed [31:0]  max_ff, max_in;
   logic [SW-1:0]       quo_ff, quo_in;
   logic [CW:0]         rem_ff, rem_in;
   logic                neg_ff, neg_in;
   logic [DW-1:0]       dcnt_ff, dcnt_in;

   logic                scan_issue;
   logic [CW:0]         trial;
   logic [SW-1:0]       sum_mag;
   logic [SW-1:0]       avg_full;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = rd_idx_ff[IW-1:0];
      found_in    = found_ff;
      where_in    = where_ff;
      status_in   = status_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;
      dcnt_in     = dcnt_ff;
      scan_issue  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IW-1:0];
      trial       = {rem_ff[CW-1:0], quo_ff[SW-1]};
      sum_mag     = '0;

      case (state_ff)
         uvt_pkg::S_IDLE: begin
            if (start) begin
               op_in     = uvt_pkg::opcode_type'(req_opcode);
               val_in    = req_value;
               rd_idx_in = '0;
               found_in  = 1'b0;
               where_in  = '0;
               if (req_opcode == uvt_pkg::OP_ADD || req_opcode == uvt_pkg::OP_SEARCH) begin
                  state_in = uvt_pkg::S_SCAN;
               end else begin
                  state_in = uvt_pkg::S_UPDATE;
               end
            end
         end
         uvt_pkg::S_SCAN: begin
            // compare the entry read last cycle
            if (pend_ff && !found_ff && rd_data_ff == val_ff) begin
               found_in = 1'b1;
               where_in = pend_idx_ff;
            end
            scan_issue = !found_in && (rd_idx_ff < count_ff);
            if (scan_issue) begin
               pend_in   = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (!pend_ff && (found_ff || rd_idx_ff >= count_ff)) begin
               state_in = uvt_pkg::S_UPDATE;
            end
         end
         uvt_pkg::S_UPDATE: begin
            pos_in = '0;
            case (op_ff)
               uvt_pkg::OP_ADD: begin
                  if (found_ff) begin
                     status_in = uvt_pkg::ST_DUPLICATE;
                  end else if (count_ff == CW'(TABLE_DEPTH)) begin
                     status_in = uvt_pkg::ST_FULL;
                  end else begin
                     status_in = uvt_pkg::ST_ADDED;
                     wr_en     = 1'b1;
                     pos_in    = count_ff[IW-1:0];
                     count_in  = count_ff + CW'(1);
                     sum_in    = sum_ff + SW'(val_ff);
                     if (count_ff == '0) begin
                        min_in = val_ff;
                        max_in = val_ff;
                     end else begin
                        if (val_ff < min_ff) min_in = val_ff;
                        if (val_ff > max_ff) max_in = val_ff;
                     end
                  end
               end
               uvt_pkg::OP_SEARCH: begin
                  if (found_ff) begin
                     status_in = uvt_pkg::ST_FOUND;
                     pos_in    = where_ff;
                  end else begin
                     status_in = uvt_pkg::ST_NOTFOUND;
                  end
               end
               uvt_pkg::OP_CLEAR: begin
                  status_in = uvt_pkg::ST_CLEARED;
                  count_in  = '0;
                  sum_in    = '0;
                  min_in    = '0;
                  max_in    = '0;
               end
               default: begin
                  status_in = uvt_pkg::ST_NOTFOUND;
               end
            endcase
            // load the divider with the magnitude of the new sum
            sum_mag = sum_in[SW-1] ? SW'(-sum_in) : SW'(sum_in);
            neg_in  = sum_in[SW-1];
            quo_in  = sum_mag;
            rem_in  = '0;
            dcnt_in = '0;
            state_in = (count_in != '0) ? uvt_pkg::S_DIVIDE : uvt_pkg::S_RESPOND;
         end
         uvt_pkg::S_DIVIDE: begin
            if (trial >= {1'b0, count_ff}) begin
               rem_in = trial - {1'b0, count_ff};
               quo_in = {quo_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[SW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DW'(1);
            if (dcnt_ff == DW'(SW - 1)) begin
               state_in = uvt_pkg::S_RESPOND;
            end
         end
         uvt_pkg::S_RESPOND: begin
            state_in = uvt_pkg::S_IDLE;
         end
         default: begin
            state_in = uvt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvt_pkg::S_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      where_ff    <= where_in;
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      dcnt_ff     <= dcnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= val_ff;
      end
      if (scan_issue) begin
         rd_data_ff <= mem[rd_idx_ff[IW-1:0]];
      end
   end

   assign avg_full        = neg_ff ? -quo_ff : quo_ff;
   assign busy            = (state_ff != uvt_pkg::S_IDLE);
   assign rsp_valid       = (state_ff == uvt_pkg::S_RESPOND);
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_smallest    = min_ff;
   assign rsp_largest     = max_ff;
   assign rsp_average     = (count_ff == '0) ? 32'sd0 : avg_full[31:0];

endmodule
`default_nettype wire

[verif/unique_value_table_with_stats_core_tb.sv]
// self-checking testbench for the unique value table with min, max and mean
module unique_value_table_with_stats_core_tb;

   localparam int Depth = uvt_pkg::TableDepthDefault;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 150;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         position;
      logic [6:0]         entry_count;
      logic               is_empty;
      logic signed [31:0] smallest;
      logic signed [31:0] largest;
      logic signed [31:0] average;
   } table_reply_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [5:0]         rsp_position;
   logic [6:0]         rsp_entry_count;
   logic               rsp_is_empty;
   logic signed [31:0] rsp_smallest;
   logic signed [31:0] rsp_largest;
   logic signed [31:0] rsp_average;

   // mirror of the table contents and its statistics
   logic signed [31:0] shadow_values [Depth];
   int                 shadow_count;
   longint             shadow_sum;
   logic signed [31:0] shadow_min;
   logic signed [31:0] shadow_max;

   table_reply_type    pending_replies[$];
   int                 failures;
   int                 stall_cycles;
   bit                 no_gaps;

   unique_value_table_with_stats_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_smallest    (rsp_smallest),
      .rsp_largest     (rsp_largest),
      .rsp_average     (rsp_average)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one command to the shadow table and returns the reply it should give
   function automatic table_reply_type table_update(uvt_pkg::opcode_type op,
                                                    logic signed [31:0] v);
      table_reply_type r;
      int hit;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_values[i] == v) hit = i;
      end
      r.status = uvt_pkg::ST_NOTFOUND;
      r.position = '0;
      case (op)
         uvt_pkg::OP_ADD: begin
            if (hit >= 0) begin
               r.status = uvt_pkg::ST_DUPLICATE;
            end else if (shadow_count >= Depth) begin
               r.status = uvt_pkg::ST_FULL;
            end else begin
               shadow_values[shadow_count] = v;
               if (shadow_count == 0) begin
                  shadow_min = v;
                  shadow_max = v;
               end else begin
                  if (v < shadow_min) shadow_min = v;
                  if (v > shadow_max) shadow_max = v;
               end
               shadow_sum += longint'(v);
               r.position = 6'(shadow_count);
               shadow_count++;
               r.status = uvt_pkg::ST_ADDED;
            end
         end
         uvt_pkg::OP_SEARCH: begin
            if (hit >= 0) begin
               r.status = uvt_pkg::ST_FOUND;
               r.position = 6'(hit);
            end
         end
         uvt_pkg::OP_CLEAR: begin
            shadow_count = 0;
            shadow_sum = 0;
            shadow_min = '0;
            shadow_max = '0;
            r.status = uvt_pkg::ST_CLEARED;
         end
         default: ;
      endcase
      r.entry_count = 7'(shadow_count);
      r.is_empty = (shadow_count == 0);
      r.smallest = shadow_min;
      r.largest = shadow_max;
      // longint division truncates toward zero
      r.average = (shadow_count != 0) ? 32'(shadow_sum / shadow_count) : '0;
      return r;
   endfunction

   task automatic send_item(input uvt_pkg::opcode_type op, input logic signed [31:0] v);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_value <= v;
      do @(posedge clock); while (busy);
      pending_replies = {pending_replies, table_update(op, v)};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_reply;
      table_reply_type want;
      if (pending_replies.size() == 0) begin
         $display("%0t: response with nothing expected, expected none, actual status %h",
                  $time, rsp_status);
         failures++;
      end else begin
         want = pending_replies.pop_front();
         check_field("status", 32'(want.status), 32'(rsp_status));
         check_field("position", 32'(want.position), 32'(rsp_position));
         check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
         check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
         check_field("smallest", want.smallest, rsp_smallest);
         check_field("largest", want.largest, rsp_largest);
         check_field("average", want.average, rsp_average);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) check_reply();
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] pick_value(int spread);
      logic signed [31:0] v;
      case ($urandom_range(0, 3))
         0: v = (shadow_count != 0) ? shadow_values[$urandom_range(0, shadow_count - 1)]
                                    : $urandom;
         1: v = int'($urandom_range(0, 2 * spread)) - spread;
         2: v = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = '0;
               default: v = '1;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic test_directed_cases;
      send_item(uvt_pkg::OP_SEARCH, 5);
      send_item(uvt_pkg::OP_ADD, 32'h8000_0000);
      send_item(uvt_pkg::OP_ADD, 32'h7fff_ffff);
      send_item(uvt_pkg::OP_ADD, 0);
      send_item(uvt_pkg::OP_ADD, -1);
      send_item(uvt_pkg::OP_ADD, 32'h7fff_ffff);
      send_item(uvt_pkg::OP_SEARCH, 0);
      send_item(uvt_pkg::OP_SEARCH, 12345);
      // unused opcode on a stored value must not report it found
      send_item(uvt_pkg::OP_UNUSED, -1);
      send_item(uvt_pkg::OP_CLEAR, 32'h7fff_ffff);
      send_item(uvt_pkg::OP_SEARCH, 32'h8000_0000);
      // negative mean truncates toward zero
      send_item(uvt_pkg::OP_ADD, -7);
      send_item(uvt_pkg::OP_ADD, 2);
      send_item(uvt_pkg::OP_ADD, -3);
      send_item(uvt_pkg::OP_UNUSED, $urandom);
      send_item(uvt_pkg::OP_CLEAR, $urandom);
      send_item(uvt_pkg::OP_ADD, 17);
      send_item(uvt_pkg::OP_SEARCH, 17);
      send_item(uvt_pkg::OP_CLEAR, 0);
   endtask

   task automatic test_full_table;
      for (int i = 0; i < Depth; i++) send_item(uvt_pkg::OP_ADD, 32'h8000_0000 + 3 * i);
      send_item(uvt_pkg::OP_ADD, 5);
      send_item(uvt_pkg::OP_ADD, 32'h8000_0000 + 3 * (Depth - 1));
      send_item(uvt_pkg::OP_SEARCH, 32'h8000_0000 + 3 * (Depth - 1));
      send_item(uvt_pkg::OP_SEARCH, 32'h8000_0000);
      send_item(uvt_pkg::OP_CLEAR, 0);
      // largest positive running sum
      for (int i = 0; i < Depth; i++) send_item(uvt_pkg::OP_ADD, 32'h7fff_ffff - i);
      send_item(uvt_pkg::OP_ADD, 0);
      send_item(uvt_pkg::OP_SEARCH, 32'h7fff_ffff - (Depth - 1));
      send_item(uvt_pkg::OP_CLEAR, $urandom);
   endtask

   task automatic test_random_traffic;
      uvt_pkg::opcode_type op;
      int pick;
      int spread;
      int add_weight;
      int items;
      for (int burst = 0; burst < 3; burst++) begin
         spread = (burst == 1) ? 40 : 1000;
         add_weight = (burst == 1) ? 70 : 55;
         items = (burst == 1) ? 150 : 100;
         send_item(uvt_pkg::OP_CLEAR, $urandom);
         for (int n = 0; n < items; n++) begin
            no_gaps = ((n / 40) % 3 == 2);
            pick = $urandom_range(0, 99);
            if (pick < add_weight) op = uvt_pkg::OP_ADD;
            else if (pick < 92) op = uvt_pkg::OP_SEARCH;
            else if (pick < 98) op = uvt_pkg::OP_UNUSED;
            else op = uvt_pkg::OP_CLEAR;
            send_item(op, pick_value(spread));
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = uvt_pkg::OP_ADD;
      req_value = '0;
      failures = 0;
      no_gaps = 1'b0;
      shadow_count = 0;
      shadow_sum = 0;
      shadow_min = '0;
      shadow_max = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_table();
      test_random_traffic();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
design/uvt_pkg.sv
design/unique_value_table_with_stats_core.sv
verif/unique_value_table_with_stats_core_tb.sv
